>>> rtl/dstat_pkg.sv
package dstat_pkg;

  localparam int SAMPLE_W      = 8;
  localparam int COUNT_W       = 7;
  localparam int SUM_W         = 14;
  localparam int MAX_COUNT_DEF = 64;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    logic                valid;
    logic                gt;
    logic [SAMPLE_W-1:0] data;
  } cell_link_t;

endpackage

>>> rtl/dstat_cell.sv
module dstat_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  dstat_pkg::cell_op_t           op,
  input  logic [dstat_pkg::SAMPLE_W-1:0] sample,
  input  logic [dstat_pkg::SAMPLE_W-1:0] head,
  input  dstat_pkg::cell_link_t         left,
  input  dstat_pkg::cell_link_t         right,
  output dstat_pkg::cell_link_t         link
);

  logic                          valid;
  logic [dstat_pkg::SAMPLE_W-1:0] data;
  logic                          gt;

  assign gt   = !valid || (data > sample);
  assign link = '{valid: valid, gt: gt, data: data};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (op)
        dstat_pkg::CELL_INSERT: valid <= valid | left.valid;
        dstat_pkg::CELL_SHIFT:  valid <= right.valid;
        default:                valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      dstat_pkg::CELL_INSERT: begin
        if (gt) begin
          data <= left.gt ? left.data : sample;
        end
      end
      dstat_pkg::CELL_ROTATE: begin
        if (valid) begin
          data <= right.valid ? right.data : head;
        end
      end
      dstat_pkg::CELL_SHIFT: data <= right.data;
      default:               data <= data;
    endcase
  end

endmodule

>>> rtl/dstat_div.sv
module dstat_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dstat_pkg::SUM_W-1:0]   dividend,
  input  logic [dstat_pkg::COUNT_W-1:0] divisor,
  output logic                          busy,
  output logic [dstat_pkg::SAMPLE_W-1:0] quotient
);

  localparam int STEP_W = $clog2(dstat_pkg::SUM_W + 1);

  logic [dstat_pkg::COUNT_W-1:0] rem;
  logic [dstat_pkg::SUM_W-1:0]   quo;
  logic [dstat_pkg::COUNT_W-1:0] dvs;
  logic [STEP_W-1:0]             steps;
  logic [dstat_pkg::COUNT_W:0]   trial;
  logic                          fits;

  assign trial    = {rem, quo[dstat_pkg::SUM_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo[dstat_pkg::SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(dstat_pkg::SUM_W);
      rem   <= '0;
      quo   <= dividend;
      dvs   <= divisor;
    end else if (busy) begin
      rem   <= fits ? dstat_pkg::COUNT_W'(trial - {1'b0, dvs})
                    : trial[dstat_pkg::COUNT_W-1:0];
      quo   <= {quo[dstat_pkg::SUM_W-2:0], fits};
      steps <= steps - STEP_W'(1);
      busy  <= steps != STEP_W'(1);
    end
  end

endmodule

>>> rtl/dataset_min_max_mean_median_unit.sv
// Data-set statistics unit.
// Input channel (in_valid/in_ready): one sample word per cycle, final_sample
// marks the last word of a set. Each kept sample is inserted into a chain of
// sorting cells in the cycle it is accepted; samples beyond MAX_COUNT are
// dropped and raise overflow. Loading runs at one word per cycle.
// After the final word the chain rotates once through all n kept samples to
// pick up the middle elements while a bit-serial divider forms the mean,
// overlapping the rotation; once the rotation is over and the divider is done,
// mean and median are registered and the first result word appears. Results then leave at
// one word per cycle from the head cell, in ascending order, each carrying
// minimum, maximum, median, mean, count and overflow; is_last marks the end.
// in_ready is low from the final word until the last result is taken.
// When out_ready is low the current result word holds and the chain stalls.
// Reset empties the chain and clears count, sum and overflow; the next set
// starts fresh after the last result of a set is accepted.
module dataset_min_max_mean_median_unit #(
  parameter int MAX_COUNT = dstat_pkg::MAX_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dstat_pkg::SAMPLE_W-1:0] sample,
  input  logic                           final_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dstat_pkg::SAMPLE_W-1:0] sorted_value,
  output logic [dstat_pkg::SAMPLE_W-1:0] minimum,
  output logic [dstat_pkg::SAMPLE_W-1:0] maximum,
  output logic [dstat_pkg::SAMPLE_W-1:0] median,
  output logic [dstat_pkg::SAMPLE_W-1:0] mean,
  output logic [dstat_pkg::COUNT_W-1:0]  count,
  output logic                           overflow,
  output logic                           is_last
);

  typedef enum logic [1:0] {ST_LOAD, ST_ROT, ST_DIV, ST_EMIT} state_t;

  state_t                         state;
  logic [dstat_pkg::COUNT_W-1:0]  kept;
  logic [dstat_pkg::SUM_W-1:0]    running_sum;
  logic [dstat_pkg::COUNT_W-1:0]  idx;
  logic [dstat_pkg::SAMPLE_W-1:0] med_lo;
  logic [dstat_pkg::SAMPLE_W-1:0] med_hi;
  logic [dstat_pkg::SAMPLE_W:0]   med_sum;
  logic                           in_acc;
  logic                           out_acc;
  logic                           full;
  logic                           last_idx;
  logic                           div_start;
  logic                           div_busy;
  logic [dstat_pkg::SAMPLE_W-1:0] div_q;
  dstat_pkg::cell_op_t            op;
  dstat_pkg::cell_link_t          link [MAX_COUNT];

  assign in_ready     = state == ST_LOAD;
  assign out_valid    = state == ST_EMIT;
  assign in_acc       = in_valid && in_ready;
  assign out_acc      = out_valid && out_ready;
  assign full         = kept == dstat_pkg::COUNT_W'(MAX_COUNT);
  assign last_idx     = idx == kept - dstat_pkg::COUNT_W'(1);
  assign div_start    = state == ST_ROT && idx == '0;
  assign med_sum      = {1'b0, med_lo} + {1'b0, med_hi};
  assign sorted_value = link[0].data;
  assign count        = kept;
  assign is_last      = last_idx;

  always_comb begin
    unique case (state)
      ST_LOAD: op = (in_acc && !full) ? dstat_pkg::CELL_INSERT : dstat_pkg::CELL_HOLD;
      ST_ROT:  op = dstat_pkg::CELL_ROTATE;
      ST_EMIT: op = out_acc ? dstat_pkg::CELL_SHIFT : dstat_pkg::CELL_HOLD;
      default: op = dstat_pkg::CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
    dstat_pkg::cell_link_t left_in;
    dstat_pkg::cell_link_t right_in;
    if (i == 0) begin : g_first
      assign left_in = '{valid: 1'b1, gt: 1'b0, data: '0};
    end else begin : g_mid_l
      assign left_in = link[i-1];
    end
    if (i == MAX_COUNT - 1) begin : g_end
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = link[i+1];
    end
    dstat_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .op     (op),
      .sample (sample),
      .head   (link[0].data),
      .left   (left_in),
      .right  (right_in),
      .link   (link[i])
    );
  end

  dstat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum),
    .divisor  (kept),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      kept        <= '0;
      running_sum <= '0;
      overflow    <= 1'b0;
      idx         <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (full) begin
              overflow <= 1'b1;
            end else begin
              kept        <= kept + dstat_pkg::COUNT_W'(1);
              running_sum <= running_sum + dstat_pkg::SUM_W'(sample);
              if (kept == '0 || sample < minimum) begin
                minimum <= sample;
              end
              if (kept == '0 || sample >= maximum) begin
                maximum <= sample;
              end
            end
            if (final_sample) begin
              state <= ST_ROT;
              idx   <= '0;
            end
          end
        end
        ST_ROT: begin
          if (idx == (kept - dstat_pkg::COUNT_W'(1)) >> 1) begin
            med_lo <= link[0].data;
          end
          if (idx == kept >> 1) begin
            med_hi <= link[0].data;
          end
          if (last_idx) begin
            idx   <= '0;
            state <= ST_DIV;
          end else begin
            idx <= idx + dstat_pkg::COUNT_W'(1);
          end
        end
        ST_DIV: begin
          if (!div_busy) begin
            mean   <= div_q;
            median <= med_sum[dstat_pkg::SAMPLE_W:1];
            state  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            if (last_idx) begin
              idx         <= '0;
              kept        <= '0;
              running_sum <= '0;
              overflow    <= 1'b0;
              state       <= ST_LOAD;
            end else begin
              idx <= idx + dstat_pkg::COUNT_W'(1);
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

>>> dv/dataset_min_max_mean_median_unit_tb.sv
`timescale 1ns / 1ps

module dataset_min_max_mean_median_unit_tb;

  localparam int SAMPLE_W       = dstat_pkg::SAMPLE_W;
  localparam int COUNT_W        = dstat_pkg::COUNT_W;
  localparam int SUM_W          = dstat_pkg::SUM_W;
  localparam int MAX_KEPT       = dstat_pkg::MAX_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int HOLD_CYCLES    = 300;

  typedef enum int {
    SPREAD_WIDE,
    SPREAD_NARROW,
    SPREAD_EDGES
  } spread_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                fin;
  } in_word_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sorted_value;
    logic [SAMPLE_W-1:0] minimum;
    logic [SAMPLE_W-1:0] maximum;
    logic [SAMPLE_W-1:0] median;
    logic [SAMPLE_W-1:0] mean;
    logic [COUNT_W-1:0]  count;
    logic                overflow;
    logic                is_last;
  } stat_word_t;

  logic                clk;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample       = '0;
  logic                final_sample = 1'b0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [SAMPLE_W-1:0] sorted_value;
  logic [SAMPLE_W-1:0] minimum;
  logic [SAMPLE_W-1:0] maximum;
  logic [SAMPLE_W-1:0] median;
  logic [SAMPLE_W-1:0] mean;
  logic [COUNT_W-1:0]  count;
  logic                overflow;
  logic                is_last;

  in_word_t            pending_words[$];
  stat_word_t          expected_stats[$];
  logic [SAMPLE_W-1:0] kept_sorted[$];
  int unsigned         sample_sum     = 0;
  bit                  drop_seen      = 1'b0;
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_idle_pct  = 0;
  int                  error_count    = 0;
  int                  words_checked  = 0;
  int                  stall_cycles   = 0;
  bit                  in_took        = 1'b0;
  bit                  hold_armed     = 1'b0;
  bit                  hold_done      = 1'b0;
  int                  hold_left      = 0;

  dataset_min_max_mean_median_unit #(
    .MAX_COUNT(MAX_KEPT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .final_sample(final_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sorted_value(sorted_value),
    .minimum(minimum),
    .maximum(maximum),
    .median(median),
    .mean(mean),
    .count(count),
    .overflow(overflow),
    .is_last(is_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [SAMPLE_W-1:0] got,
                             input logic [SAMPLE_W-1:0] want);
    if (got !== want)
      report_error($sformatf("word %0d %s: got %0d, want %0d", words_checked, name,
                             got, want));
  endtask

  task automatic absorb_sample(input logic [SAMPLE_W-1:0] v, input logic fin);
    int         pos;
    int         n;
    int         mid;
    stat_word_t w;
    if (kept_sorted.size() < MAX_KEPT) begin
      pos = kept_sorted.size();
      while (pos > 0 && kept_sorted[pos-1] > v) pos--;
      kept_sorted.insert(pos, v);
      sample_sum = (sample_sum + v) & ((1 << SUM_W) - 1);
    end else begin
      drop_seen = 1'b1;
    end
    if (fin) begin
      n = kept_sorted.size();
      if (n != 0) begin
        if (n % 2 == 1)
          mid = kept_sorted[n/2];
        else
          mid = (int'(kept_sorted[(n-1)/2]) + int'(kept_sorted[n/2])) / 2;
        for (int k = 0; k < n; k++) begin
          w.sorted_value = kept_sorted[k];
          w.minimum      = kept_sorted[0];
          w.maximum      = kept_sorted[n-1];
          w.median       = SAMPLE_W'(mid);
          w.mean         = SAMPLE_W'(sample_sum / n);
          w.count        = COUNT_W'(n);
          w.overflow     = drop_seen;
          w.is_last      = (k == n - 1);
          expected_stats.push_back(w);
        end
      end
      kept_sorted.delete();
      sample_sum = 0;
      drop_seen  = 1'b0;
    end
  endtask

  task automatic check_word();
    stat_word_t want;
    if (expected_stats.size() == 0) begin
      report_error($sformatf("unexpected result word, sorted_value %0d", sorted_value));
    end else begin
      want = expected_stats.pop_front();
      check_field("sorted_value", sorted_value, want.sorted_value);
      check_field("minimum", minimum, want.minimum);
      check_field("maximum", maximum, want.maximum);
      check_field("median", median, want.median);
      check_field("mean", mean, want.mean);
      check_field("count", SAMPLE_W'(count), SAMPLE_W'(want.count));
      check_field("overflow", SAMPLE_W'(overflow), SAMPLE_W'(want.overflow));
      check_field("is_last", SAMPLE_W'(is_last), SAMPLE_W'(want.is_last));
    end
    words_checked++;
  endtask

  always @(posedge clk) begin
    in_took = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) check_word();
      if (in_valid && in_ready) begin
        absorb_sample(sample, final_sample);
        in_took = 1'b1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("dataset_min_max_mean_median_unit_tb failed");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid     <= 1'b1;
        sample       <= pending_words[0].sample;
        final_sample <= pending_words[0].fin;
        void'(pending_words.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // hold off once on a full set so the next set backs up at the input
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done && out_valid) begin
      out_ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_word(input logic [SAMPLE_W-1:0] v, input logic fin);
    in_word_t w;
    w.sample = v;
    w.fin    = fin;
    pending_words.push_back(w);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input spread_t spread,
                                                      input logic [SAMPLE_W-1:0] base);
    case (spread)
      SPREAD_WIDE:   return SAMPLE_W'($urandom_range(255));
      SPREAD_NARROW: return base + SAMPLE_W'($urandom_range(3));
      default:       return $urandom_range(1) ? {SAMPLE_W{1'b1}} : '0;
    endcase
  endfunction

  task automatic queue_set(input int len, input spread_t spread);
    logic [SAMPLE_W-1:0] base;
    base = SAMPLE_W'($urandom_range(255));
    for (int i = 0; i < len; i++) push_word(pick_sample(spread, base), i == len - 1);
  endtask

  task automatic queue_random_sets(input int budget);
    int      len;
    int      roll;
    spread_t spread;
    while (budget > 0) begin
      roll = $urandom_range(99);
      if (roll < 60)      len = $urandom_range(8, 1);
      else if (roll < 80) len = $urandom_range(40, 9);
      else if (roll < 90) len = $urandom_range(MAX_KEPT, 41);
      else                len = $urandom_range(MAX_KEPT + 6, MAX_KEPT + 1);
      roll = $urandom_range(99);
      if (roll < 60)      spread = SPREAD_WIDE;
      else if (roll < 85) spread = SPREAD_NARROW;
      else                spread = SPREAD_EDGES;
      queue_set(len, spread);
      budget -= len;
    end
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_stats.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    send_idle_pct = 18;
    recv_idle_pct = 71;
    push_word(8'd0, 1'b1);
    push_word(8'd255, 1'b1);
    push_word(8'd0, 1'b0);
    push_word(8'd255, 1'b1);
    push_word(8'd7, 1'b0);
    push_word(8'd3, 1'b0);
    push_word(8'd7, 1'b0);
    push_word(8'd3, 1'b1);
    push_word(8'd200, 1'b0);
    push_word(8'd10, 1'b0);
    push_word(8'd255, 1'b0);
    push_word(8'd0, 1'b0);
    push_word(8'd128, 1'b1);
    push_word(8'd1, 1'b0);
    push_word(8'd2, 1'b0);
    push_word(8'd254, 1'b1);
    queue_random_sets(150);
    wait_idle();

    send_idle_pct = 71;
    recv_idle_pct = 18;
    queue_random_sets(150);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed    = 1'b1;
    queue_set(MAX_KEPT, SPREAD_WIDE);
    queue_set(MAX_KEPT + 1, SPREAD_NARROW);
    queue_random_sets(100);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_stats.size() != 0)
      report_error($sformatf("%0d result words never arrived", expected_stats.size()));
    if (error_count == 0)
      $display("dataset_min_max_mean_median_unit_tb passed");
    else
      $display("dataset_min_max_mean_median_unit_tb failed");
    $finish;
  end

endmodule

>>> dataset_min_max_mean_median_unit.f
rtl/dstat_pkg.sv
rtl/dstat_cell.sv
rtl/dstat_div.sv
rtl/dataset_min_max_mean_median_unit.sv
dv/dataset_min_max_mean_median_unit_tb.sv
